// ----- rtl/mlr_pkg.sv -----
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared types and constants of the midpoint line rasterizer: command codes,
// register indexes, the input and result transactions and the queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

package mlr_pkg;

  // coordinate and register widths
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned CFG_BITS   = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned SUM_W      = COORD_BITS + CFG_BITS;
  localparam int unsigned DX_W       = COORD_BITS + 1;
  localparam int unsigned DEC_W      = COORD_BITS + 3;

  // small queues between the parts (depth must be a power of two)
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register reset values
  localparam logic [CFG_BITS-1:0] CENTER_X_RST = CFG_BITS'(512);
  localparam logic [CFG_BITS-1:0] CENTER_Y_RST = CFG_BITS'(384);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = CFG_IDX_W'(1);

  // command codes of an input transaction
  localparam logic [1:0] CMD_MOVE = 2'd0;
  localparam logic [1:0] CMD_LINE = 2'd1;
  localparam logic [1:0] CMD_STEP = 2'd2;

  // classified operation handed to the walker
  typedef enum logic [1:0] {
    OP_MOVE,
    OP_LINE,
    OP_STEP,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [1:0]                   cmd;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
  } item_t;

  typedef struct packed {
    logic                         pixel_valid;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         last;
  } result_t;

  // line setup produced by the front part
  typedef struct packed {
    op_e                          op;
    logic signed [COORD_BITS-1:0] walk_x;
    logic signed [COORD_BITS-1:0] walk_y;
    logic signed [COORD_BITS-1:0] end_major;
    logic signed [DEC_W-1:0]      decision;
    logic signed [DEC_W-1:0]      inc_straight;
    logic signed [DEC_W-1:0]      inc_diagonal;
    logic                         steep;
    logic                         y_down;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/mlr_front.sv -----
// ----------------------------------------------------------------------------
// mlr_front
// Accepts commands, maps user coordinates to the screen, tracks the current
// position and computes the midpoint setup of each line in two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mlr_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output logic                                 full,
  input  wire mlr_pkg::item_t                  item_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [mlr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [mlr_pkg::CFG_BITS-1:0]    cfg_data_i,
  output logic                                 q_push_o,
  input  wire logic                            q_full_i,
  output mlr_pkg::entry_t                      q_entry_o
);
  import mlr_pkg::*;

  logic [CFG_BITS-1:0]          center_x_q, center_y_q;
  logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q;
  logic                         a_valid_q;
  op_e                          a_op_q, op_d;
  logic signed [COORD_BITS-1:0] a_xs_q, a_ys_q, a_xe_q, a_ye_q;
  logic                         accept;
  logic [SUM_W-1:0]             sum_x, sum_y;
  logic signed [COORD_BITS-1:0] tx, ty;
  logic                         swap;
  logic signed [DX_W-1:0]       dx, dy, ady, major, minor;
  logic                         steep;

  // stage a holds until the queue takes it
  assign full   = a_valid_q && q_full_i;
  assign accept = push && !full;

  // user to screen mapping, wraps to the coordinate width
  assign sum_x = SUM_W'(center_x_q) + SUM_W'($signed(item_i.pos_x));
  assign sum_y = SUM_W'(center_y_q) - SUM_W'($signed(item_i.pos_y));
  assign tx    = sum_x[COORD_BITS-1:0];
  assign ty    = sum_y[COORD_BITS-1:0];
  assign swap  = tx > cur_x_q;

  // command decoder
  always_comb begin
    unique case (item_i.cmd)
      CMD_MOVE: op_d = OP_MOVE;
      CMD_LINE: op_d = OP_LINE;
      CMD_STEP: op_d = OP_STEP;
      default:  op_d = OP_NOP;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= CENTER_X_RST;
      center_y_q <= CENTER_Y_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CENTER_X: center_x_q <= cfg_data_i;
        CFG_CENTER_Y: center_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // current position and stage a valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= COORD_BITS'(CENTER_X_RST);
      cur_y_q   <= COORD_BITS'(CENTER_Y_RST);
      a_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_q <= 1'b1;
        if (op_d == OP_MOVE || op_d == OP_LINE) begin
          cur_x_q <= tx;
          cur_y_q <= ty;
        end
      end else if (q_push_o) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  // stage a payload: endpoints ordered by x
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_op_q <= op_d;
      a_xs_q <= swap ? cur_x_q : tx;
      a_ys_q <= swap ? cur_y_q : ty;
      a_xe_q <= swap ? tx : cur_x_q;
      a_ye_q <= swap ? ty : cur_y_q;
    end
  end

  // stage b: deltas, octant and midpoint terms
  assign dx    = DX_W'(a_xe_q) - DX_W'(a_xs_q);
  assign dy    = DX_W'(a_ye_q) - DX_W'(a_ys_q);
  assign ady   = dy[DX_W-1] ? -dy : dy;
  assign steep = ady > dx;
  assign major = steep ? ady : dx;
  assign minor = steep ? dx : ady;

  always_comb begin
    q_entry_o              = '0;
    q_entry_o.op           = a_op_q;
    q_entry_o.walk_x       = a_xs_q;
    q_entry_o.walk_y       = a_ys_q;
    q_entry_o.end_major    = steep ? a_ye_q : a_xe_q;
    q_entry_o.inc_straight = DEC_W'(minor) + DEC_W'(minor);
    q_entry_o.decision     = DEC_W'(minor) + DEC_W'(minor) - DEC_W'(major);
    q_entry_o.inc_diagonal = DEC_W'(minor) + DEC_W'(minor)
                             - DEC_W'(major) - DEC_W'(major);
    q_entry_o.steep        = steep;
    q_entry_o.y_down       = dy[DX_W-1];
  end

  assign q_push_o = a_valid_q && !q_full_i;

endmodule

`default_nettype wire

// ----- rtl/mlr_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// mlr_cmd_queue
// Short queue of line setups between the front part and the walker.
// ----------------------------------------------------------------------------
`default_nettype none

module mlr_cmd_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  output logic                 full_o,
  input  wire mlr_pkg::entry_t entry_i,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output mlr_pkg::entry_t      entry_o
);
  import mlr_pkg::*;

  entry_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                do_push, do_pop;

  assign full_o  = count_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
      if (do_pop)  rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
      count_q <= QCNT_W'(count_q + QCNT_W'(do_push) - QCNT_W'(do_pop));
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule

`default_nettype wire

// ----- rtl/mlr_back.sv -----
// ----------------------------------------------------------------------------
// mlr_back
// Line walker: runs the midpoint recurrence one pixel per transaction and
// buffers the results in a short output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mlr_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_empty_i,
  input  wire mlr_pkg::entry_t q_entry_i,
  output logic                 q_pop_o,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output mlr_pkg::result_t     result_o
);
  import mlr_pkg::*;

  // walk state
  logic signed [COORD_BITS-1:0] walk_x_q, walk_y_q, end_major_q;
  logic signed [DEC_W-1:0]      decision_q, inc_s_q, inc_d_q;
  logic                         steep_q, y_down_q, drawing_q;

  // current terms of this transaction
  logic signed [COORD_BITS-1:0] c_x, c_y, c_end, c_major, n_x, n_y;
  logic signed [DEC_W-1:0]      c_dec, c_inc_s, c_inc_d, n_dec;
  logic                         c_steep, c_down, is_line, emit, fin, diag, take;
  result_t                      res;

  // output queue
  result_t                      out_mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]            wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]            count_q;
  logic                         out_full, do_pop;

  assign out_full = count_q == QCNT_W'(QUEUE_DEPTH);
  assign take     = !q_empty_i && !out_full;
  assign q_pop_o  = take;

  // a line load starts from the queued setup, a step from the walk state
  assign is_line = q_entry_i.op == OP_LINE;
  assign emit    = is_line || (q_entry_i.op == OP_STEP && drawing_q);
  assign c_x     = is_line ? q_entry_i.walk_x       : walk_x_q;
  assign c_y     = is_line ? q_entry_i.walk_y       : walk_y_q;
  assign c_end   = is_line ? q_entry_i.end_major    : end_major_q;
  assign c_dec   = is_line ? q_entry_i.decision     : decision_q;
  assign c_inc_s = is_line ? q_entry_i.inc_straight : inc_s_q;
  assign c_inc_d = is_line ? q_entry_i.inc_diagonal : inc_d_q;
  assign c_steep = is_line ? q_entry_i.steep        : steep_q;
  assign c_down  = is_line ? q_entry_i.y_down       : y_down_q;

  assign c_major = c_steep ? c_y : c_x;
  assign fin     = c_major == c_end;
  assign diag    = !c_dec[DEC_W-1] && (c_dec != '0);

  // next pixel of the walk
  always_comb begin
    n_dec = c_dec + (diag ? c_inc_d : c_inc_s);
    if (c_steep) begin
      n_x = diag ? COORD_BITS'(c_x + 1'b1) : c_x;
      n_y = c_down ? COORD_BITS'(c_y - 1'b1) : COORD_BITS'(c_y + 1'b1);
    end else begin
      n_x = COORD_BITS'(c_x + 1'b1);
      if (diag) begin
        n_y = c_down ? COORD_BITS'(c_y - 1'b1) : COORD_BITS'(c_y + 1'b1);
      end else begin
        n_y = c_y;
      end
    end
  end

  // result of this transaction
  always_comb begin
    res = '0;
    if (emit) begin
      res.pixel_valid = 1'b1;
      res.pixel_x     = c_x;
      res.pixel_y     = c_y;
      res.last        = fin;
    end
  end

  // drawing flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drawing_q <= 1'b0;
    end else if (take) begin
      if (q_entry_i.op == OP_MOVE) begin
        drawing_q <= 1'b0;
      end else if (emit) begin
        drawing_q <= !fin;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_x_q    <= '0;
      walk_y_q    <= '0;
      end_major_q <= '0;
      decision_q  <= '0;
      inc_s_q     <= '0;
      inc_d_q     <= '0;
      steep_q     <= 1'b0;
      y_down_q    <= 1'b0;
    end else if (take && emit) begin
      walk_x_q    <= fin ? c_x : n_x;
      walk_y_q    <= fin ? c_y : n_y;
      decision_q  <= fin ? c_dec : n_dec;
      end_major_q <= c_end;
      inc_s_q     <= c_inc_s;
      inc_d_q     <= c_inc_d;
      steep_q     <= c_steep;
      y_down_q    <= c_down;
    end
  end

  // output queue pointers and fill count
  assign empty_o  = count_q == '0;
  assign do_pop   = pop_i && !empty_o;
  assign result_o = out_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (take)   wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
      if (do_pop) rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
      count_q <= QCNT_W'(count_q + QCNT_W'(take) - QCNT_W'(do_pop));
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_mem_q[wr_ptr_q] <= res;
  end

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("output queue overfilled");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && emit && fin) |=> !drawing_q)
    else $error("line still active after its last pixel");

  a_move_aborts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && q_entry_i.op == OP_MOVE) |=> !drawing_q)
    else $error("move did not abort the line");

  a_idle_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !result_o.pixel_valid) |->
      (result_o.pixel_x == '0 && result_o.pixel_y == '0 && !result_o.last))
    else $error("result without pixel carries data");

endmodule

`default_nettype wire

// ----- rtl/midpoint_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// Turtle-style midpoint line rasterizer: move_to, line_to and step commands
// produce one result transaction each, carrying at most one pixel.
//
// Input side is a queue write port: a command is taken at a clock edge with
// push high and full low. Results leave through a queue read port: the oldest
// result sits on result_o while empty is low and is taken with pop.
// The user must write the center registers through cfg_we_i/cfg_idx_i/cfg_data_i
// only while the block is idle; the block itself does not enforce this.
// A command passes the setup stage register and the setup queue before the
// walker writes its result into the output queue. Throughput: one command per
// cycle while full is low; the walker does one decision add and one end
// compare per pixel.
// Two-entry queues sit after the setup stage and before the result port;
// when the receiver stops popping, results fill the output queue, then the
// setup queue and the setup stage, then full rises; nothing is dropped.
// Reset clears both queues, ends any line and puts the current position and
// the center registers back at column 512, row 384.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_line_rasterizer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output logic                                 full,
  input  wire mlr_pkg::item_t                  item_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output mlr_pkg::result_t                     result_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [mlr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [mlr_pkg::CFG_BITS-1:0]    cfg_data_i
);
  import mlr_pkg::*;

  logic   fq_push, fq_full, bq_empty, bq_pop;
  entry_t fq_entry, bq_entry;

  mlr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_push_o   (fq_push),
    .q_full_i   (fq_full),
    .q_entry_o  (fq_entry)
  );

  mlr_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .full_o  (fq_full),
    .entry_i (fq_entry),
    .pop_i   (bq_pop),
    .empty_o (bq_empty),
    .entry_o (bq_entry)
  );

  mlr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (bq_empty),
    .q_entry_i (bq_entry),
    .q_pop_o   (bq_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .result_o  (result_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the midpoint line rasterizer. A behavioral model of
// the turtle commands and the midpoint walk predicts one result transaction
// per command; a monitor pops results under random back-pressure and compares
// every field in order. Directed tests cover idle commands, the line octants,
// aborted lines and extreme center settings; a random phase follows with
// mostly complete short lines, some broken ones and raw noise.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mlr_pkg::*;

  localparam int LATENCY      = 2;
  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 750;
  localparam int CFG_EVERY    = 150;
  localparam int COORD_MAX    = 2 ** (COORD_BITS - 1) - 1;
  localparam int COORD_MIN    = -(2 ** (COORD_BITS - 1));
  localparam logic [1:0]          CMD_NONE   = 2'd3;
  localparam logic [CFG_BITS-1:0] CENTER_MAX = '1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  item_t                item_in;
  logic                 empty;
  logic                 pop;
  result_t              result_out;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_BITS-1:0]  cfg_data;

  midpoint_line_rasterizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item_in),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_out),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // model state: origin, pen position and the line walker
  logic [CFG_BITS-1:0]          org_x, org_y;
  logic signed [COORD_BITS-1:0] pen_x, pen_y;
  logic signed [COORD_BITS-1:0] walk_x, walk_y, stop_major;
  logic signed [DEC_W-1:0]      err_acc, err_straight, err_diag;
  logic                         walk_steep, walk_ydn, walk_busy;

  result_t pixel_q[$];
  int      errors       = 0;
  int      items_sent   = 0;
  int      quiet_cycles = 0;
  bit      tx_calm      = 1'b0;
  bit      rx_calm      = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // random idle length: mostly short, a few long, with calm stretches
  function automatic int idle_len(inout bit calm);
    int r;
    if ($urandom_range(63) == 0) calm = !calm;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic item_t pack_item(input logic [1:0] cmd, input int x, input int y);
    item_t it;
    it.cmd   = cmd;
    it.pos_x = COORD_BITS'(x);
    it.pos_y = COORD_BITS'(y);
    return it;
  endfunction

  function automatic int rand_delta();
    int span;
    span = ($urandom_range(9) == 0) ? 40 : 6;
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic logic [CFG_BITS-1:0] random_center();
    case ($urandom_range(3))
      0:       return '0;
      1:       return CENTER_MAX;
      default: return CFG_BITS'($urandom_range(CENTER_MAX));
    endcase
  endfunction

  // emit the walker pixel and advance one step along the major axis
  task automatic plot_pixel(output result_t px);
    logic signed [COORD_BITS-1:0] major;
    major          = walk_steep ? walk_y : walk_x;
    px.pixel_valid = 1'b1;
    px.pixel_x     = walk_x;
    px.pixel_y     = walk_y;
    px.last        = (major == stop_major);
    walk_busy      = !px.last;
    if (!px.last) begin
      // minor axis moves when the decision term is positive
      if (err_acc > 0) begin
        err_acc = err_acc + err_diag;
        if (walk_steep) begin
          walk_x = COORD_BITS'(walk_x + 1);
        end else if (walk_ydn) begin
          walk_y = COORD_BITS'(walk_y - 1);
        end else begin
          walk_y = COORD_BITS'(walk_y + 1);
        end
      end else begin
        err_acc = err_acc + err_straight;
      end
      // major axis always moves
      if (!walk_steep) begin
        walk_x = COORD_BITS'(walk_x + 1);
      end else if (walk_ydn) begin
        walk_y = COORD_BITS'(walk_y - 1);
      end else begin
        walk_y = COORD_BITS'(walk_y + 1);
      end
    end
  endtask

  // expected result of one accepted command
  task automatic predict_item(input item_t it);
    logic signed [COORD_BITS-1:0] tgt_x, tgt_y;
    int      xs, ys, xe, ye, run, rise, rise_abs;
    result_t px;
    px = '0;
    case (it.cmd) inside
      CMD_MOVE, CMD_LINE: begin
        // user to screen, wrapping at the coordinate width
        tgt_x     = $signed({1'b0, org_x}) + it.pos_x;
        tgt_y     = $signed({1'b0, org_y}) - it.pos_y;
        walk_busy = 1'b0;
        if (it.cmd == CMD_LINE) begin
          // walk from the end with the smaller x
          if (tgt_x > pen_x) begin
            xs = int'(pen_x);
            ys = int'(pen_y);
            xe = int'(tgt_x);
            ye = int'(tgt_y);
          end else begin
            xs = int'(tgt_x);
            ys = int'(tgt_y);
            xe = int'(pen_x);
            ye = int'(pen_y);
          end
          run        = xe - xs;
          rise       = ye - ys;
          rise_abs   = (rise < 0) ? -rise : rise;
          walk_ydn   = rise < 0;
          walk_steep = rise_abs > run;
          walk_x     = COORD_BITS'(xs);
          walk_y     = COORD_BITS'(ys);
          if (walk_steep) begin
            err_acc      = DEC_W'(2 * run - rise_abs);
            err_straight = DEC_W'(2 * run);
            err_diag     = DEC_W'(2 * (run - rise_abs));
            stop_major   = COORD_BITS'(ye);
          end else begin
            err_acc      = DEC_W'(2 * rise_abs - run);
            err_straight = DEC_W'(2 * rise_abs);
            err_diag     = DEC_W'(2 * (rise_abs - run));
            stop_major   = COORD_BITS'(xe);
          end
          plot_pixel(px);
        end
        pen_x = tgt_x;
        pen_y = tgt_y;
      end
      CMD_STEP: begin
        if (walk_busy) plot_pixel(px);
      end
      default: ;
    endcase
    pixel_q = {pixel_q, px};
  endtask

  // one input transaction, after a random gap
  task automatic send_item(input item_t it);
    int gap;
    gap = idle_len(tx_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    item_in <= it;
    do @(posedge clk_i); while (full !== 1'b0);
    predict_item(it);
    if (it.cmd != CMD_NONE) items_sent++;
  endtask

  // stop sending and let every pending result come out
  task automatic wait_idle();
    push <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_centers(input logic [CFG_BITS-1:0] cx, input logic [CFG_BITS-1:0] cy);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_CENTER_X;
    cfg_data <= cx;
    @(posedge clk_i);
    cfg_idx  <= CFG_CENTER_Y;
    cfg_data <= cy;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    org_x = cx;
    org_y = cy;
  endtask

  // line to a point given as a screen offset from the pen
  task automatic line_rel(input int dx, input int dy);
    int tx, ty;
    tx = int'(pen_x) + dx;
    if (tx > COORD_MAX || tx < COORD_MIN) tx = int'(pen_x) - dx;
    ty = int'(pen_y) + dy;
    if (ty > COORD_MAX || ty < COORD_MIN) ty = int'(pen_y) - dy;
    send_item(pack_item(CMD_LINE, tx - int'(org_x), int'(org_y) - ty));
  endtask

  task automatic send_step();
    send_item(pack_item(CMD_STEP, $urandom, $urandom));
  endtask

  task automatic finish_line();
    while (walk_busy) send_step();
  endtask

  // steps and unused codes while idle, moves, zero-length line, wrap
  task automatic test_idle_commands();
    send_step();
    send_item(pack_item(CMD_NONE, $urandom, $urandom));
    send_item(pack_item(CMD_MOVE, 0, 0));
    send_item(pack_item(CMD_LINE, 0, 0));
    send_item(pack_item(CMD_MOVE, COORD_MIN, COORD_MIN));
    send_item(pack_item(CMD_MOVE, COORD_MAX, COORD_MAX));
    send_step();
    send_item(pack_item(CMD_MOVE, 0, 0));
  endtask

  // shallow and steep, up and down, vertical and diagonal
  task automatic test_octants();
    int dxs[6] = '{2, 2, 1, -1, 0, 2};
    int dys[6] = '{1, -1, -2, -2, 2, 2};
    foreach (dxs[i]) begin
      line_rel(dxs[i], dys[i]);
      finish_line();
    end
  endtask

  // unused code keeps a line, line_to and move_to drop it
  task automatic test_abort();
    line_rel(4, 3);
    send_step();
    send_item(pack_item(CMD_NONE, $urandom, $urandom));
    send_step();
    line_rel(-3, 1);
    send_step();
    send_item(pack_item(CMD_MOVE, $urandom, $urandom));
    send_step();
  endtask

  // center registers at their extremes
  task automatic test_config_extremes();
    write_centers('0, CENTER_MAX);
    send_item(pack_item(CMD_MOVE, COORD_MIN, COORD_MAX));
    line_rel(1, 1);
    finish_line();
    write_centers(CENTER_MAX, '0);
    send_item(pack_item(CMD_LINE, COORD_MAX, COORD_MIN));
    send_step();
    send_step();
    send_item(pack_item(CMD_MOVE, 0, 0));
  endtask

  // mostly complete short lines, some broken ones, some noise
  task automatic test_random();
    int kind;
    int next_cfg;
    items_sent = 0;
    next_cfg   = CFG_EVERY;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= next_cfg) begin
        next_cfg += CFG_EVERY;
        write_centers(random_center(), random_center());
      end
      kind = $urandom_range(99);
      if (kind < 70) begin
        line_rel(rand_delta(), rand_delta());
        while (walk_busy) begin
          send_item(pack_item(($urandom_range(19) == 0) ? CMD_NONE : CMD_STEP,
                              $urandom, $urandom));
        end
        if ($urandom_range(9) == 0) send_step();
      end else if (kind < 85) begin
        if ($urandom_range(1) == 0) begin
          send_item(pack_item(CMD_LINE, $urandom, $urandom));
        end else begin
          line_rel(rand_delta(), rand_delta());
        end
        repeat ($urandom_range(4)) send_step();
        if ($urandom_range(1) == 0) send_item(pack_item(CMD_MOVE, $urandom, $urandom));
      end else begin
        repeat ($urandom_range(3, 1)) begin
          send_item(pack_item(2'($urandom_range(3)), $urandom, $urandom));
        end
      end
    end
  endtask

  // stimulus
  initial begin : stimulus
    push     <= 1'b0;
    item_in  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CFG_CENTER_X;
    cfg_data <= '0;
    rst_ni   <= 1'b0;
    org_x        = CENTER_X_RST;
    org_y        = CENTER_Y_RST;
    pen_x        = COORD_BITS'(CENTER_X_RST);
    pen_y        = COORD_BITS'(CENTER_Y_RST);
    walk_x       = '0;
    walk_y       = '0;
    stop_major   = '0;
    err_acc      = '0;
    err_straight = '0;
    err_diag     = '0;
    walk_steep   = 1'b0;
    walk_ydn     = 1'b0;
    walk_busy    = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_commands();
    test_octants();
    test_abort();
    test_config_extremes();
    test_random();

    wait_idle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result monitor with random back-pressure
  initial begin : result_monitor
    int      stall;
    int      burst;
    result_t want;
    pop  <= 1'b0;
    stall = 0;
    burst = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && empty === 1'b0) begin
        if (pixel_q.size() == 0) begin
          $error("result transaction with nothing pending: valid %0b x %0d y %0d last %0b",
                 result_out.pixel_valid, result_out.pixel_x, result_out.pixel_y,
                 result_out.last);
          errors++;
        end else begin
          want = pixel_q.pop_front();
          if (result_out.pixel_valid !== want.pixel_valid) begin
            $error("pixel_valid expected %0b actual %0b", want.pixel_valid,
                   result_out.pixel_valid);
            errors++;
          end
          if (result_out.pixel_x !== want.pixel_x) begin
            $error("pixel_x expected %0d actual %0d", want.pixel_x, result_out.pixel_x);
            errors++;
          end
          if (result_out.pixel_y !== want.pixel_y) begin
            $error("pixel_y expected %0d actual %0d", want.pixel_y, result_out.pixel_y);
            errors++;
          end
          if (result_out.last !== want.last) begin
            $error("last expected %0b actual %0b", want.last, result_out.last);
            errors++;
          end
        end
      end
      // next pop level: a stall, then a burst of pops
      if (stall == 0 && burst == 0) begin
        stall = idle_len(rx_calm);
        burst = $urandom_range(12, 1);
      end
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        burst--;
      end
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((push && full === 1'b0) || (pop && empty === 1'b0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
